[design/anca_pkg.sv]
// Shared constants, codes and types for the ARP neighbor cache with aging.
`timescale 1ns / 1ps
package anca_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IFACE_COUNT   = 4;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int TREE_SIZE     = 1 << IDX_W;
  localparam int TREE_LEVELS   = IDX_W;
  localparam int CNT_W         = $clog2(TREE_LEVELS + 1);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] REG_OWN_IP_0 = 3'd0;
  localparam logic [2:0] REG_OWN_IP_1 = 3'd1;
  localparam logic [2:0] REG_OWN_IP_2 = 3'd2;
  localparam logic [2:0] REG_OWN_IP_3 = 3'd3;
  localparam logic [2:0] REG_LIFETIME = 3'd4;

  localparam logic [30:0] LIFETIME_RESET = 31'd1200;
  localparam logic [2:0]  IFACE_LIMIT    = 3'(IFACE_COUNT);
  localparam logic [31:0] SIGN_BIT       = 32'h8000_0000;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [1:0]       iface;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [31:0]      expiry;
  } tbl_wr_t;

  typedef struct packed {
    logic             match_any;
    logic [IDX_W-1:0] match_idx;
    logic [47:0]      match_mac;
    logic [31:0]      match_expiry;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
  } tbl_look_t;

endpackage

[design/anca_table.sv]
// Neighbor entry storage with parallel match and first free slot search.
`timescale 1ns / 1ps
module anca_table
  import anca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  key_iface,
  input  logic [31:0] key_ip,
  input  tbl_wr_t     wr,
  output tbl_look_t   look,
  output logic [31:0] expiry [TABLE_ENTRIES]
);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [1:0]               iface [TABLE_ENTRIES];
  logic [31:0]              ip    [TABLE_ENTRIES];
  logic [47:0]              mac   [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] hit_first;
  logic [TABLE_ENTRIES-1:0] free_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.set) begin
      valid[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      iface[wr.idx]  <= wr.iface;
      ip[wr.idx]     <= wr.ip;
      mac[wr.idx]    <= wr.mac;
      expiry[wr.idx] <= wr.expiry;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (iface[i] == key_iface) && (ip[i] == key_ip);
    end
    hit_first  = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
    free_first = ~valid & (valid + TABLE_ENTRIES'(1));
  end

  always_comb begin
    look = '0;
    look.match_any = |hit_vec;
    look.free_any  = ~&valid;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_first[i]) begin
        look.match_idx    = look.match_idx | IDX_W'(i);
        look.match_mac    = look.match_mac | mac[i];
        look.match_expiry = look.match_expiry | expiry[i];
      end
      if (free_first[i]) begin
        look.free_idx = look.free_idx | IDX_W'(i);
      end
    end
  end

endmodule

[design/anca_victim.sv]
// Registered minimum tree that finds the entry nearest expiry.
`timescale 1ns / 1ps
module anca_victim
  import anca_pkg::*;
(
  input  logic             clk,
  input  logic [31:0]      time_now,
  input  logic [31:0]      expiry [TABLE_ENTRIES],
  output logic [IDX_W-1:0] victim_idx
);

  logic [31:0]      leaf_key  [TREE_SIZE];
  logic [31:0]      node_key  [1:TREE_SIZE-1];
  logic [IDX_W-1:0] node_idx  [1:TREE_SIZE-1];
  logic [31:0]      left_key  [1:TREE_SIZE-1];
  logic [31:0]      right_key [1:TREE_SIZE-1];
  logic [IDX_W-1:0] left_idx  [1:TREE_SIZE-1];
  logic [IDX_W-1:0] right_idx [1:TREE_SIZE-1];

  always_comb begin
    for (int i = 0; i < TREE_SIZE; i++) begin
      if (i < TABLE_ENTRIES) begin
        leaf_key[i] = (expiry[i] - time_now) ^ SIGN_BIT;
      end else begin
        leaf_key[i] = '1;
      end
    end
  end

  always_comb begin
    for (int i = 1; i < TREE_SIZE; i++) begin
      if (2 * i >= TREE_SIZE) begin
        left_key[i]  = leaf_key[2 * i - TREE_SIZE];
        right_key[i] = leaf_key[2 * i + 1 - TREE_SIZE];
        left_idx[i]  = IDX_W'(2 * i - TREE_SIZE);
        right_idx[i] = IDX_W'(2 * i + 1 - TREE_SIZE);
      end else begin
        left_key[i]  = node_key[2 * i];
        right_key[i] = node_key[2 * i + 1];
        left_idx[i]  = node_idx[2 * i];
        right_idx[i] = node_idx[2 * i + 1];
      end
    end
  end

  // lower index wins ties
  always_ff @(posedge clk) begin
    for (int i = 1; i < TREE_SIZE; i++) begin
      if (left_key[i] <= right_key[i]) begin
        node_key[i] <= left_key[i];
        node_idx[i] <= left_idx[i];
      end else begin
        node_key[i] <= right_key[i];
        node_idx[i] <= right_idx[i];
      end
    end
  end

  assign victim_idx = node_idx[1];

endmodule

[design/arp_neighbor_cache_aging_top.sv]
// Top level of the ARP neighbor cache with entry aging.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | req_valid / req_stall  | operation iface ip mac is_request target_ip
//   response | rsp_valid / rsp_stall  | hit found_mac learned reply_needed
//            |                        | release_pending
//   config   | wr_en                  | wr_index wr_data
//
// One transaction per cycle unless a response stall or an eviction search holds
// the flow: each item is held in the input register and its result is registered.
// A learn that finds no match and no free slot waits in the search and pick states
// for the victim search tree to settle.
// Reset clears valid bits, time counter, own IPs and valid flags; reloads lifetime.
// A stalled response holds the input register; the request side stalls with it.
`timescale 1ns / 1ps
module arp_neighbor_cache_aging_top
  import anca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [1:0]  iface,
  input  logic [31:0] ip,
  input  logic [47:0] mac,
  input  logic        is_request,
  input  logic [31:0] target_ip,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic [47:0] found_mac,
  output logic        learned,
  output logic        reply_needed,
  output logic        release_pending
);

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_PICK   = 2'd2;

  logic [31:0] own_ip [4];
  logic [30:0] lifetime;
  logic [31:0] time_now;

  logic        item_valid;
  logic [1:0]  item_op;
  logic [1:0]  item_iface;
  logic [31:0] item_ip;
  logic [47:0] item_mac;
  logic        item_req;
  logic [31:0] item_tgt;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;

  tbl_wr_t          wr;
  tbl_look_t        look;
  logic [31:0]      expiry [TABLE_ENTRIES];
  logic [IDX_W-1:0] victim_idx;

  logic        iface_ok;
  logic        learnable;
  logic        is_packet;
  logic        is_lookup;
  logic        need_evict;
  logic        can_out;
  logic        proc_go;
  logic        expired;
  logic [31:0] age;

  anca_table u_table (
    .clk       (clk),
    .rst       (rst),
    .key_iface (item_iface),
    .key_ip    (item_ip),
    .wr        (wr),
    .look      (look),
    .expiry    (expiry)
  );

  anca_victim u_victim (
    .clk        (clk),
    .time_now   (time_now),
    .expiry     (expiry),
    .victim_idx (victim_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip   <= '{default: '0};
      lifetime <= LIFETIME_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OWN_IP_0: own_ip[0] <= wr_data;
        REG_OWN_IP_1: own_ip[1] <= wr_data;
        REG_OWN_IP_2: own_ip[2] <= wr_data;
        REG_OWN_IP_3: own_ip[3] <= wr_data;
        REG_LIFETIME: lifetime  <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  assign iface_ok   = {1'b0, item_iface} < IFACE_LIMIT;
  assign is_packet  = (item_op == OP_PACKET) && iface_ok;
  assign is_lookup  = (item_op == OP_LOOKUP) && iface_ok;
  assign learnable  = (item_ip != '0) && (item_mac != '0);
  assign need_evict = is_packet && learnable && !look.match_any && !look.free_any;
  assign age        = time_now - look.match_expiry;
  assign expired    = (age != '0) && !age[31];

  assign can_out   = !rsp_valid || !rsp_stall;
  assign proc_go   = item_valid && can_out &&
                     ((state == ST_PICK) || ((state == ST_RUN) && !need_evict));
  assign req_stall = item_valid && !proc_go;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (item_valid && need_evict) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cnt == CNT_W'(TREE_LEVELS - 1)) state_next = ST_PICK;
      end
      ST_PICK: begin
        if (proc_go) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    wr        = '0;
    wr.iface  = item_iface;
    wr.ip     = item_ip;
    wr.mac    = item_mac;
    wr.expiry = time_now + {1'b0, lifetime};
    if (look.match_any) begin
      wr.idx = look.match_idx;
    end else if (look.free_any) begin
      wr.idx = look.free_idx;
    end else begin
      wr.idx = victim_idx;
    end
    if (proc_go && is_packet && learnable) begin
      wr.set = 1'b1;
    end
    if (proc_go && is_lookup && look.match_any && expired) begin
      wr.clr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      time_now   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        item_valid <= 1'b1;
      end else if (proc_go) begin
        item_valid <= 1'b0;
      end
      if (proc_go && (item_op == OP_TICK)) begin
        time_now <= time_now + 32'd1;
      end
      if (proc_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item_op    <= operation;
      item_iface <= iface;
      item_ip    <= ip;
      item_mac   <= mac;
      item_req   <= is_request;
      item_tgt   <= target_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      hit             <= is_lookup && look.match_any && !expired;
      found_mac       <= (is_lookup && look.match_any && !expired) ? look.match_mac : '0;
      learned         <= is_packet && learnable;
      reply_needed    <= is_packet && item_req && (own_ip[item_iface] != '0) &&
                         (item_tgt == own_ip[item_iface]);
      release_pending <= is_packet;
    end
  end

endmodule
